FILE: rtl/core/boot_reply_frame_checker_defines.svh
// ----------------------------------------------------------------------------
// boot reply frame checker assertion macros
// shared assertion shorthands for the checker module
// ----------------------------------------------------------------------------
`ifndef BOOT_REPLY_FRAME_CHECKER_DEFINES_SVH
`define BOOT_REPLY_FRAME_CHECKER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BRFC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define BRFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/brfc_pkg.sv
// ----------------------------------------------------------------------------
// brfc_pkg
// constants and types shared by the boot reply frame checker modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brfc_pkg;

	// frame layout
	localparam logic [7:0] FRAME_HEADER      = 8'hEA;
	localparam logic [4:0] MAX_PAYLOAD       = 5'd16;
	localparam logic [4:0] POS_MAX           = 5'd31;
	localparam logic [5:0] MIN_ACK_BYTES     = 6'd5;
	localparam logic [5:0] MIN_VERSION_BYTES = 6'd8;
	localparam logic [5:0] CHECKSUM_OFFSET   = 6'd3;
	localparam logic [5:0] FRAME_OVERHEAD    = 6'd4;

	// byte positions of the fixed fields
	localparam logic [4:0] POS_HEADER = 5'd0;
	localparam logic [4:0] POS_SERIAL = 5'd1;
	localparam logic [4:0] POS_CMDLEN = 5'd2;
	localparam logic [4:0] POS_DATA0  = 5'd3;
	localparam logic [4:0] POS_DATA1  = 5'd4;
	localparam logic [4:0] POS_DATA2  = 5'd5;
	localparam logic [4:0] POS_DATA3  = 5'd6;

	// commands
	localparam logic [2:0] CMD_ACK     = 3'd0;
	localparam logic [2:0] CMD_VERSION = 3'd4;

	// status codes
	localparam logic [2:0] STATUS_ACK          = 3'd0;
	localparam logic [2:0] STATUS_VERSION      = 3'd1;
	localparam logic [2:0] STATUS_BAD_HEADER   = 3'd2;
	localparam logic [2:0] STATUS_TOO_SHORT    = 3'd3;
	localparam logic [2:0] STATUS_BAD_LENGTH   = 3'd4;
	localparam logic [2:0] STATUS_BAD_CHECKSUM = 3'd5;
	localparam logic [2:0] STATUS_MISMATCH     = 3'd6;

	// registered input byte handed to the evaluation stage
	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] data;
	} s1_t;

endpackage

`default_nettype wire

FILE: rtl/core/boot_reply_frame_checker.sv
// The final byte of a buffer passes the input register, then the result register.
// Throughput: one byte per cycle, except while a final byte waits for a held result.
// Reset: arst_n clears the expected serial, the frame state and the result valid flag.
// Outputs hold while out_valid is high and out_ready is low.
// ----------------------------------------------------------------------------
// boot_reply_frame_checker
// checks a bootloader reply frame byte by byte and reports ack/version status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module boot_reply_frame_checker #(
	parameter logic [4:0] MAX_PAYLOAD = brfc_pkg::MAX_PAYLOAD
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        end_of_buffer,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             ack_ok,
	output logic             version_ok,
	output logic [31:0]      version_word,
	output logic [2:0]       status
);

	brfc_pkg::s1_t s1;
	logic          advance;

	// input byte register
	brfc_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.end_of_buffer (end_of_buffer),
		.advance       (advance),
		.s1            (s1)
	);

	// frame tracking and result register
	brfc_frame_eval #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_frame_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s1           (s1),
		.advance      (advance),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ack_ok       (ack_ok),
		.version_ok   (version_ok),
		.version_word (version_word),
		.status       (status)
	);

endmodule

`default_nettype wire

FILE: rtl/core/brfc_in_reg.sv
// ----------------------------------------------------------------------------
// brfc_in_reg
// input register stage: captures one received byte per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brfc_in_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     rx_byte,
	input  wire logic           end_of_buffer,
	input  wire logic           advance,
	output brfc_pkg::s1_t       s1
);

	logic       valid_s1;
	logic       last_s1;
	logic [7:0] data_s1;

	// stage frees up when empty or when its byte moves on
	assign in_ready = !valid_s1 || advance;

	// stage valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload capture on transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= rx_byte;
			last_s1 <= end_of_buffer;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.last  = last_s1;
	assign s1.data  = data_s1;

endmodule

`default_nettype wire

FILE: rtl/core/brfc_frame_eval.sv
// ----------------------------------------------------------------------------
// brfc_frame_eval
// frame state tracking, final checks and the result output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brfc_frame_eval #(
	parameter logic [4:0] MAX_PAYLOAD = brfc_pkg::MAX_PAYLOAD
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_wr_en,
	input  wire logic [7:0]     cfg_wr_data,
	input  wire brfc_pkg::s1_t  s1,
	output logic                advance,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic                ack_ok,
	output logic                version_ok,
	output logic [31:0]         version_word,
	output logic [2:0]          status
);

	logic [7:0]  expected_serial_q;
	logic [4:0]  pos_q;
	logic [7:0]  xor_q;
	logic        header_q;
	logic [7:0]  serial_q;
	logic [7:0]  cmdlen_q;
	logic [31:0] lead_q;
	logic        ck_q;

	logic        header_n;
	logic [7:0]  serial_n;
	logic [7:0]  cmdlen_n;
	logic [31:0] lead_n;
	logic [7:0]  xor_n;
	logic        ck_n;
	logic [4:0]  pos_n;
	logic [4:0]  dlen;
	logic [2:0]  cmd;
	logic [5:0]  pos_w;
	logic [5:0]  total;
	logic [5:0]  ck_pos;
	logic [5:0]  need_bytes;
	logic        res_ack;
	logic        res_ver;
	logic [31:0] res_word;
	logic [2:0]  res_status;

	logic        out_valid_q;
	logic        ack_q;
	logic        ver_q;
	logic [31:0] word_q;
	logic [2:0]  status_q;

	// byte moves on unless it is final and the result register is blocked
	assign advance = s1.valid && (!s1.last || !out_valid_q || out_ready);

	// expected serial register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_serial_q <= 8'd0;
		end else if (cfg_wr_en) begin
			expected_serial_q <= cfg_wr_data;
		end
	end

	// field capture by position
	always_comb begin
		header_n = header_q;
		serial_n = serial_q;
		cmdlen_n = cmdlen_q;
		lead_n   = lead_q;
		case (pos_q)
			brfc_pkg::POS_HEADER: header_n = (s1.data == brfc_pkg::FRAME_HEADER);
			brfc_pkg::POS_SERIAL: serial_n = s1.data;
			brfc_pkg::POS_CMDLEN: cmdlen_n = s1.data;
			brfc_pkg::POS_DATA0:  lead_n[7:0]   = s1.data;
			brfc_pkg::POS_DATA1:  lead_n[15:8]  = s1.data;
			brfc_pkg::POS_DATA2:  lead_n[23:16] = s1.data;
			brfc_pkg::POS_DATA3:  lead_n[31:24] = s1.data;
			default: ;
		endcase
	end

	// running xor and checksum compare
	assign dlen   = cmdlen_n[4:0];
	assign cmd    = cmdlen_n[7:5];
	assign pos_w  = {1'b0, pos_q};
	assign ck_pos = {1'b0, dlen} + brfc_pkg::CHECKSUM_OFFSET;

	always_comb begin
		xor_n = xor_q;
		ck_n  = ck_q;
		if (pos_q >= brfc_pkg::POS_DATA0 && pos_w == ck_pos) begin
			ck_n = (s1.data == xor_q);
		end else if (pos_q < brfc_pkg::POS_DATA0 || pos_w < ck_pos) begin
			xor_n = xor_q ^ s1.data;
		end
	end

	// saturating byte count
	assign pos_n = (pos_q == brfc_pkg::POS_MAX) ? pos_q : pos_q + 5'd1;

	// final checks, first failure wins
	assign total      = pos_w + 6'd1;
	assign need_bytes = {1'b0, dlen} + brfc_pkg::FRAME_OVERHEAD;

	always_comb begin
		res_ack    = 1'b0;
		res_ver    = 1'b0;
		res_word   = 32'd0;
		res_status = brfc_pkg::STATUS_MISMATCH;
		if (!header_n) begin
			res_status = brfc_pkg::STATUS_BAD_HEADER;
		end else if (total < brfc_pkg::MIN_ACK_BYTES) begin
			res_status = brfc_pkg::STATUS_TOO_SHORT;
		end else if (dlen > MAX_PAYLOAD || need_bytes > total) begin
			res_status = brfc_pkg::STATUS_BAD_LENGTH;
		end else if (!ck_n) begin
			res_status = brfc_pkg::STATUS_BAD_CHECKSUM;
		end else if (cmd == brfc_pkg::CMD_ACK) begin
			if (serial_n == expected_serial_q && lead_n[7:0] == 8'd0) begin
				res_status = brfc_pkg::STATUS_ACK;
				res_ack    = 1'b1;
			end
		end else if (cmd == brfc_pkg::CMD_VERSION) begin
			if (total < brfc_pkg::MIN_VERSION_BYTES) begin
				res_status = brfc_pkg::STATUS_TOO_SHORT;
			end else if (serial_n == expected_serial_q) begin
				res_status = brfc_pkg::STATUS_VERSION;
				res_ver    = 1'b1;
				res_word   = lead_n;
			end
		end
	end

	// frame state, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 5'd0;
			xor_q    <= 8'd0;
			header_q <= 1'b0;
			serial_q <= 8'd0;
			cmdlen_q <= 8'd0;
			lead_q   <= 32'd0;
			ck_q     <= 1'b0;
		end else if (advance) begin
			if (s1.last) begin
				pos_q    <= 5'd0;
				xor_q    <= 8'd0;
				header_q <= 1'b0;
				serial_q <= 8'd0;
				cmdlen_q <= 8'd0;
				lead_q   <= 32'd0;
				ck_q     <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				xor_q    <= xor_n;
				header_q <= header_n;
				serial_q <= serial_n;
				cmdlen_q <= cmdlen_n;
				lead_q   <= lead_n;
				ck_q     <= ck_n;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && s1.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && s1.last) begin
			ack_q    <= res_ack;
			ver_q    <= res_ver;
			word_q   <= res_word;
			status_q <= res_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign ack_ok       = ack_q;
	assign version_ok   = ver_q;
	assign version_word = word_q;
	assign status       = status_q;

endmodule

`default_nettype wire

FILE: rtl/core/brfc_checker.sv
// ----------------------------------------------------------------------------
// brfc_checker
// port-level assertions for the boot reply frame checker, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "boot_reply_frame_checker_defines.svh"

module brfc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        ack_ok,
	input wire logic        version_ok,
	input wire logic [31:0] version_word,
	input wire logic [2:0]  status
);

	// ack flag agrees with its status code and excludes a version reply
	`BRFC_ASSERT_NOW(a_ack_status, out_valid && ack_ok, status == brfc_pkg::STATUS_ACK && !version_ok, "ack_ok without ack status")

	// version flag agrees with its status code
	`BRFC_ASSERT_NOW(a_ver_status, out_valid && version_ok, status == brfc_pkg::STATUS_VERSION, "version_ok without version status")

	// version word is zero unless the reply is a valid version reply
	`BRFC_ASSERT_NOW(a_word_zero, out_valid && !version_ok, version_word == 32'd0, "version_word set on non-version result")

	// a stalled result holds
	`BRFC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(version_word), "result changed while stalled")

endmodule

bind boot_reply_frame_checker brfc_checker u_brfc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.ack_ok       (ack_ok),
	.version_ok   (version_ok),
	.version_word (version_word),
	.status       (status)
);

`default_nettype wire

FILE: tb/reply_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reply verdict checker
// watches the byte and verdict channels of the boot reply frame checker,
// rebuilds the frame state from every byte transfer, predicts the verdict of
// each buffer and compares it field by field with the verdict transfers
// ----------------------------------------------------------------------------
module reply_verdict_checker
	import brfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_buffer,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        ack_ok,
	input  logic        version_ok,
	input  logic [31:0] version_word,
	input  logic [2:0]  status,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic        ack;
		logic        ver;
		logic [31:0] word;
		logic [2:0]  status;
	} reply_verdict_t;

	reply_verdict_t expected_verdicts[$];

	// mirrored frame state
	logic [7:0]  serial_cfg;
	logic [4:0]  frame_pos;
	logic [7:0]  xor_acc;
	logic        hdr_good;
	logic [7:0]  rx_serial;
	logic [7:0]  cmdlen;
	logic [31:0] lead_data;
	logic        sum_good;

	task automatic log_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic clear_frame();
		frame_pos = '0;
		xor_acc   = '0;
		hdr_good  = 1'b0;
		rx_serial = '0;
		cmdlen    = '0;
		lead_data = '0;
		sum_good  = 1'b0;
	endtask

	// fold one received byte into the frame state, predict a verdict on the last one
	task automatic absorb_byte(input logic [7:0] b, input logic last);
		int p;
		int total;
		int dlen;
		logic [2:0] cmd;
		reply_verdict_t v;
		p = frame_pos;
		total = p + 1;
		if (p == POS_HEADER) hdr_good = (b == FRAME_HEADER);
		if (p == POS_SERIAL) rx_serial = b;
		if (p == POS_CMDLEN) cmdlen = b;
		if (p >= POS_DATA0 && p <= POS_DATA3)
			lead_data = lead_data | (32'(b) << (8 * (p - POS_DATA0)));

		// checksum byte sits right after the data, bytes past it stay out of the xor
		dlen = cmdlen[4:0];
		if (p >= POS_DATA0 && p == dlen + CHECKSUM_OFFSET) begin
			sum_good = (b == xor_acc);
		end else if (p < POS_DATA0 || p < dlen + CHECKSUM_OFFSET) begin
			xor_acc = xor_acc ^ b;
		end
		if (frame_pos < POS_MAX) frame_pos++;

		if (last) begin
			cmd = cmdlen[7:5];
			v = '0;
			if (!hdr_good) begin
				v.status = STATUS_BAD_HEADER;
			end else if (total < MIN_ACK_BYTES) begin
				v.status = STATUS_TOO_SHORT;
			end else if (dlen > MAX_PAYLOAD || dlen + FRAME_OVERHEAD > total) begin
				v.status = STATUS_BAD_LENGTH;
			end else if (!sum_good) begin
				v.status = STATUS_BAD_CHECKSUM;
			end else if (cmd == CMD_ACK) begin
				if (rx_serial == serial_cfg && lead_data[7:0] == 8'h00) begin
					v.ack = 1'b1;
					v.status = STATUS_ACK;
				end else begin
					v.status = STATUS_MISMATCH;
				end
			end else if (cmd == CMD_VERSION) begin
				if (total < MIN_VERSION_BYTES) begin
					v.status = STATUS_TOO_SHORT;
				end else if (rx_serial == serial_cfg) begin
					v.ver = 1'b1;
					v.word = lead_data;
					v.status = STATUS_VERSION;
				end else begin
					v.status = STATUS_MISMATCH;
				end
			end else begin
				v.status = STATUS_MISMATCH;
			end
			expected_verdicts.push_back(v);
			clear_frame();
		end
	endtask

	// compare one verdict transfer with the oldest prediction
	task automatic check_verdict();
		reply_verdict_t want;
		if (expected_verdicts.size() == 0) begin
			log_mismatch($sformatf("verdict with no buffer pending, status %0d", status));
		end else begin
			want = expected_verdicts.pop_front();
			if (ack_ok !== want.ack)
				log_mismatch($sformatf("ack_ok got %b want %b", ack_ok, want.ack));
			if (version_ok !== want.ver)
				log_mismatch($sformatf("version_ok got %b want %b", version_ok, want.ver));
			if (version_word !== want.word)
				log_mismatch($sformatf("version_word got %h want %h", version_word, want.word));
			if (status !== want.status)
				log_mismatch($sformatf("status got %0d want %0d", status, want.status));
		end
	endtask

	// sample both channels and the register port at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serial_cfg = '0;
			clear_frame();
			expected_verdicts.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en === 1'b1) serial_cfg = cfg_wr_data;
			if (out_valid === 1'b1 && out_ready) check_verdict();
			if (in_valid && in_ready === 1'b1) absorb_byte(rx_byte, end_of_buffer);
			pending = expected_verdicts.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boot reply frame checker testbench
// drives reply buffers byte by byte with random gaps and verdict stalls:
// a few hand-built frames, then random well-formed, damaged and noise
// buffers under several expected serial settings; the checker module
// predicts and compares every verdict
// ----------------------------------------------------------------------------
module testbench;
	import brfc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        end_of_buffer;
	logic        out_valid;
	logic        out_ready;
	logic        ack_ok;
	logic        version_ok;
	logic [31:0] version_word;
	logic [2:0]  status;
	int          fail_count;
	int          pending;

	logic        calm;
	logic [7:0]  cur_serial;
	logic [7:0]  frame_buf[$];
	int          sent_bytes;

	boot_reply_frame_checker i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.end_of_buffer(end_of_buffer),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ack_ok       (ack_ok),
		.version_ok   (version_ok),
		.version_word (version_word),
		.status       (status)
	);

	reply_verdict_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.end_of_buffer(end_of_buffer),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ack_ok       (ack_ok),
		.version_ok   (version_ok),
		.version_word (version_word),
		.status       (status),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// verdict side back-pressure
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = calm || ($urandom_range(0, 99) >= 34);
		end
	end

	// one byte transfer, entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!calm && $urandom_range(0, 99) < 34) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		end_of_buffer = last;
		do @(posedge clk); while (in_ready !== 1'b1);
		sent_bytes++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		frame_buf.delete();
	endtask

	// header, serial, cmd/length, data, xor checksum
	task automatic build_frame(input logic [2:0] cmd, input int dlen, input logic [7:0] ser,
			input logic zero_first);
		logic [7:0] sum;
		frame_buf.delete();
		frame_buf.push_back(FRAME_HEADER);
		frame_buf.push_back(ser);
		frame_buf.push_back({cmd, 5'(dlen)});
		for (int i = 0; i < dlen; i++)
			frame_buf.push_back((i == 0 && zero_first) ? 8'h00 : 8'($urandom));
		sum = '0;
		foreach (frame_buf[i]) sum = sum ^ frame_buf[i];
		frame_buf.push_back(sum);
	endtask

	// hold off until every verdict is back and the pipeline has emptied
	task automatic wait_drained();
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_expected_serial(input logic [7:0] v);
		in_valid = 1'b0;
		wait_drained();
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		cur_serial = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// one random buffer: mostly well-formed replies, some damaged, some noise
	task automatic random_frame();
		int kind;
		int dlen;
		int n;
		logic [2:0] cmd;
		logic [7:0] ser;
		kind = $urandom_range(0, 99);
		ser = ($urandom_range(0, 4) == 0) ? 8'($urandom) : cur_serial;
		if (kind < 95) begin
			if (kind < 30) begin
				cmd = CMD_ACK;
				dlen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
			end else if (kind < 60) begin
				cmd = CMD_VERSION;
				dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 16);
			end else if (kind < 70) begin
				cmd = 3'($urandom);
				dlen = $urandom_range(0, 16);
			end else begin
				cmd = $urandom_range(0, 1) ? CMD_ACK : ($urandom_range(0, 1) ? CMD_VERSION : 3'($urandom));
				dlen = $urandom_range(0, 16);
			end
			// oversized length field, in the longest cases long enough to saturate the position
			if (kind >= 90) dlen = $urandom_range(17, 31);
			build_frame(cmd, dlen, ser, $urandom_range(0, 4) != 0);
			if (kind >= 70 && kind < 80)
				frame_buf[frame_buf.size() - 1] ^= 8'($urandom_range(1, 255));
			if (kind >= 80 && kind < 85)
				frame_buf[0] ^= 8'($urandom_range(1, 255));
			if (kind >= 85 && kind < 90) begin
				n = $urandom_range(1, frame_buf.size() - 1);
				while (frame_buf.size() > n) void'(frame_buf.pop_back());
			end
			// trailing bytes after the checksum
			if ($urandom_range(0, 6) == 0) begin
				n = $urandom_range(1, 3);
				repeat (n) frame_buf.push_back(8'($urandom));
			end
		end else begin
			frame_buf.delete();
			n = $urandom_range(1, 40);
			repeat (n) frame_buf.push_back(8'($urandom));
			if ($urandom_range(0, 1)) frame_buf[0] = FRAME_HEADER;
		end
		send_frame();
	endtask

	// stimulus
	initial begin
		logic [7:0] phase_serial[5];
		int target;
		logic paused;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		end_of_buffer = 1'b0;
		calm = 1'b0;
		cur_serial = '0;
		sent_bytes = 0;
		paused = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed frames
		set_expected_serial(8'hFF);
		frame_buf.push_back(8'h00);
		send_frame();
		frame_buf.push_back(FRAME_HEADER);
		frame_buf.push_back(cur_serial);
		send_frame();
		build_frame(CMD_ACK, 1, cur_serial, 1'b1);
		send_frame();
		build_frame(CMD_VERSION, 4, cur_serial, 1'b0);
		send_frame();
		build_frame(CMD_ACK, 1, cur_serial, 1'b1);
		frame_buf[POS_CMDLEN] = {CMD_ACK, POS_MAX};
		send_frame();
		build_frame(CMD_ACK, 1, cur_serial, 1'b1);
		frame_buf[frame_buf.size() - 1] ^= 8'h80;
		send_frame();
		build_frame(CMD_ACK, 1, ~cur_serial, 1'b1);
		send_frame();

		// random phases under different serial settings
		phase_serial[0] = 8'h00;
		phase_serial[1] = 8'($urandom);
		phase_serial[2] = 8'hFF;
		phase_serial[3] = 8'($urandom);
		phase_serial[4] = 8'h80;
		for (int phase = 0; phase < 5; phase++) begin
			set_expected_serial(phase_serial[phase]);
			calm = (phase == 2);
			target = sent_bytes + 110;
			while (sent_bytes < target) begin
				random_frame();
				if (phase == 3 && !paused && sent_bytes > target - 60) begin
					in_valid = 1'b0;
					wait_drained();
					paused = 1'b1;
				end
			end
		end
		in_valid = 1'b0;
		calm = 1'b0;

		// let the last verdicts drain
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/brfc_pkg.sv
rtl/core/brfc_in_reg.sv
rtl/core/brfc_frame_eval.sv
rtl/core/boot_reply_frame_checker.sv
rtl/core/brfc_checker.sv
tb/reply_verdict_checker.sv
tb/testbench.sv
